/* sv/printable_run_extractor_unit_macros.svh */
// Assertion macros for the printable run extractor checker.
// Expects clk_i and rst_ni in the scope of use.
`ifndef PRINTABLE_RUN_EXTRACTOR_UNIT_MACROS_SVH
`define PRINTABLE_RUN_EXTRACTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define PRX_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("prx assertion failed");

// Next-cycle implication.
`define PRX_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("prx assertion failed");

`endif

/* sv/prx_pkg.sv */
// Shared types and constants for the printable run extractor.
// Used by prx_ctrl, prx_datapath, the top level and the checker.
package prx_pkg;

  localparam int unsigned PendingDepth = 63;
  localparam int unsigned OffsetBits   = 32;
  localparam int unsigned PtrW         = $clog2(PendingDepth);
  localparam int unsigned CntW         = $clog2(PendingDepth + 1);
  localparam int unsigned SumW         = CntW + 1;

  localparam logic [7:0] CharTab     = 8'h09;
  localparam logic [7:0] CharSpace   = 8'h20;
  localparam logic [7:0] CharVisLow  = 8'h21;
  localparam logic [7:0] CharTilde   = 8'h7E;
  localparam logic [5:0] MinLengthReset = 6'd4;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       stream_end;
  } in_req_t;

  typedef struct packed {
    logic [7:0]  char_out;
    logic [31:0] run_offset;
    logic        last_of_run;
    logic        truncated;
  } out_req_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_EMIT_HELD,
    S_DRAIN_RD,
    S_DRAIN_OUT,
    S_FINISH,
    S_EMIT_LAST
  } state_e;

  typedef struct packed {
    logic in_run;
    logic run_end;
    logic qualified;
    logic held_valid;
    logic qualify_now;
    logic drain_multi;
    logic drain_more;
    logic out_free;
  } status_t;

  typedef struct packed {
    logic accept;
    logic push;
    logic hold;
    logic emit_held;
    logic emit_last;
    logic clear_run;
    logic drain_rd;
    logic drain_out;
  } cmd_t;

endpackage

/* sv/printable_run_extractor_unit.sv */
// Printable run extractor: finds runs of printable bytes or tab in a byte stream.
// Request channel: in_valid_i / in_stall_o carry one in_req_t (byte, stream_end).
// A request is taken at a rising edge with in_valid_i high and in_stall_o low.
// Result channel: out_valid_o / out_stall_i carry one out_req_t per reported byte.
// Configuration: cfg_we_i writes cfg_wdata_i into min_length (reset 4); write
// it only while the block is idle.
// One request at a time: a byte that reports nothing passes through the step
// and finish states, a byte passed through also visits the held-byte emit state,
// and a byte that qualifies a run of N buffered bytes adds a read and an output
// state for each of the N-1 bytes read through the pending buffer's single
// registered read port. A byte that ends a reported run adds a last-result state.
// Results leave through a one-entry output register; a stall on the result side
// holds that register and the sequencer waits at its next result, while the
// request side stays stalled until the current byte is done.
// Reset clears all run state, the stream offset and the output valid flag; the
// pending buffer needs no clearing since only written entries are read.
module printable_run_extractor_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  prx_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output prx_pkg::out_req_t out_req_o
);

  prx_pkg::cmd_t    cmd;
  prx_pkg::status_t status;

  prx_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  prx_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o),
    .cmd_i       (cmd),
    .status_o    (status)
  );

endmodule

/* sv/prx_ctrl.sv */
// Sequencer of the printable run extractor: steps one request at a time.
// Depends on prx_pkg; drives commands into prx_datapath.
module prx_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  prx_pkg::status_t status_i,
  output prx_pkg::cmd_t    cmd_o
);

  prx_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= prx_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = (state_q != prx_pkg::S_IDLE);
    case (state_q)
      prx_pkg::S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = prx_pkg::S_STEP;
        end
      end
      prx_pkg::S_STEP: begin
        state_d = prx_pkg::S_FINISH;
        if (status_i.in_run) begin
          if (status_i.qualified) begin
            if (status_i.held_valid) begin
              state_d = prx_pkg::S_EMIT_HELD;
            end else begin
              cmd_o.hold = 1'b1;
            end
          end else begin
            cmd_o.push = 1'b1;
            if (status_i.qualify_now && status_i.drain_multi) begin
              state_d = prx_pkg::S_DRAIN_RD;
            end
          end
        end
      end
      prx_pkg::S_EMIT_HELD: begin
        if (status_i.out_free) begin
          cmd_o.emit_held = 1'b1;
          cmd_o.hold      = 1'b1;
          state_d         = prx_pkg::S_FINISH;
        end
      end
      prx_pkg::S_DRAIN_RD: begin
        cmd_o.drain_rd = 1'b1;
        state_d        = prx_pkg::S_DRAIN_OUT;
      end
      prx_pkg::S_DRAIN_OUT: begin
        if (status_i.out_free) begin
          cmd_o.drain_out = 1'b1;
          state_d = status_i.drain_more ? prx_pkg::S_DRAIN_RD : prx_pkg::S_FINISH;
        end
      end
      prx_pkg::S_FINISH: begin
        state_d = prx_pkg::S_IDLE;
        if (status_i.run_end) begin
          if (status_i.qualified && status_i.held_valid) begin
            state_d = prx_pkg::S_EMIT_LAST;
          end else begin
            cmd_o.clear_run = 1'b1;
          end
        end
      end
      prx_pkg::S_EMIT_LAST: begin
        if (status_i.out_free) begin
          cmd_o.emit_last = 1'b1;
          state_d         = prx_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = prx_pkg::S_IDLE;
      end
    endcase
  end

endmodule

/* sv/prx_datapath.sv */
// Datapath of the printable run extractor: pending ring buffer, run state,
// offset counters and output register. Depends on prx_pkg; driven by prx_ctrl.
module prx_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [5:0]        cfg_wdata_i,
  input  prx_pkg::in_req_t  in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output prx_pkg::out_req_t out_req_o,
  input  prx_pkg::cmd_t     cmd_i,
  output prx_pkg::status_t  status_o
);

  logic [7:0] pend_mem [prx_pkg::PendingDepth];

  logic [prx_pkg::CntW-1:0]       count_q, count_d;
  logic [prx_pkg::PtrW-1:0]       head_q, head_d;
  logic [prx_pkg::CntW-1:0]       left_q, left_d;
  logic                           qual_q, qual_d;
  logic                           seen_q, seen_d;
  logic                           held_valid_q, held_valid_d;
  logic [7:0]                     held_q, held_d;
  logic                           dropped_q, dropped_d;
  logic [prx_pkg::OffsetBits-1:0] start_q, start_d;
  logic [prx_pkg::OffsetBits-1:0] pos_q, pos_d;
  logic [5:0]                     min_len_q, min_len_d;
  logic                           out_valid_q, out_valid_d;

  logic [7:0]        byte_q;
  logic              end_q;
  logic [7:0]        rdata_q;
  prx_pkg::out_req_t out_q, out_d;

  logic [prx_pkg::CntW-1:0] thr;
  logic [prx_pkg::SumW-1:0] tail_sum;
  logic [prx_pkg::SumW-1:0] tail_wrap;
  logic [prx_pkg::PtrW-1:0] tail;
  logic [prx_pkg::PtrW-1:0] head_inc;
  logic                     full;
  logic [prx_pkg::CntW-1:0] count_new;
  logic                     in_run;
  logic                     visible;
  logic                     seen_new;
  logic                     qualify_now;
  logic                     emit;
  logic [7:0]               emit_char;

  always_comb begin
    thr = prx_pkg::CntW'(min_len_q);
    if (min_len_q == 6'd0) begin
      thr = prx_pkg::CntW'(1);
    end else if (int'(min_len_q) > prx_pkg::PendingDepth) begin
      thr = prx_pkg::CntW'(prx_pkg::PendingDepth);
    end
  end

  assign tail_sum  = prx_pkg::SumW'(head_q) + prx_pkg::SumW'(count_q);
  assign tail_wrap = (tail_sum >= prx_pkg::SumW'(prx_pkg::PendingDepth))
                     ? tail_sum - prx_pkg::SumW'(prx_pkg::PendingDepth) : tail_sum;
  assign tail      = tail_wrap[prx_pkg::PtrW-1:0];
  assign head_inc  = (head_q == prx_pkg::PtrW'(prx_pkg::PendingDepth - 1))
                     ? '0 : head_q + 1'b1;

  assign full        = (count_q == prx_pkg::CntW'(prx_pkg::PendingDepth));
  assign count_new   = full ? count_q : count_q + 1'b1;
  assign in_run      = ((byte_q >= prx_pkg::CharSpace) && (byte_q <= prx_pkg::CharTilde))
                       || (byte_q == prx_pkg::CharTab);
  assign visible     = (byte_q >= prx_pkg::CharVisLow) && (byte_q <= prx_pkg::CharTilde);
  assign seen_new    = seen_q | visible;
  assign qualify_now = (count_new >= thr) && seen_new;

  assign status_o.in_run      = in_run;
  assign status_o.run_end     = !in_run || end_q;
  assign status_o.qualified   = qual_q;
  assign status_o.held_valid  = held_valid_q;
  assign status_o.qualify_now = qualify_now;
  assign status_o.drain_multi = (count_new > prx_pkg::CntW'(1));
  assign status_o.drain_more  = (left_q != '0);
  assign status_o.out_free    = !out_valid_q || !out_stall_i;

  assign emit      = cmd_i.emit_held | cmd_i.emit_last | cmd_i.drain_out;
  assign emit_char = cmd_i.drain_out ? rdata_q : held_q;

  always_comb begin
    count_d      = count_q;
    head_d       = head_q;
    left_d       = left_q;
    qual_d       = qual_q;
    seen_d       = seen_q;
    held_valid_d = held_valid_q;
    held_d       = held_q;
    dropped_d    = dropped_q;
    start_d      = start_q;
    pos_d        = pos_q;
    min_len_d    = min_len_q;
    out_valid_d  = out_valid_q;
    out_d        = out_q;

    if (cfg_we_i) begin
      min_len_d = cfg_wdata_i;
    end

    if (cmd_i.accept) begin
      if ((count_q == '0) && !qual_q) begin
        start_d = pos_q;
      end
      pos_d = in_req_i.stream_end ? '0 : pos_q + 1'b1;
    end

    if (cmd_i.push) begin
      count_d = count_new;
      seen_d  = seen_new;
      if (full) begin
        head_d    = head_inc;
        dropped_d = 1'b1;
      end
      if (qualify_now) begin
        qual_d       = 1'b1;
        held_d       = byte_q;
        held_valid_d = 1'b1;
        left_d       = count_new - 1'b1;
        count_d      = '0;
      end
    end

    if (cmd_i.hold) begin
      held_d       = byte_q;
      held_valid_d = 1'b1;
    end

    if (cmd_i.drain_rd) begin
      head_d = head_inc;
      left_d = left_q - 1'b1;
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d       = 1'b1;
      out_d.char_out    = emit_char;
      out_d.run_offset  = 32'(start_q);
      out_d.last_of_run = cmd_i.emit_last;
      out_d.truncated   = dropped_q;
    end

    if (cmd_i.clear_run || cmd_i.emit_last) begin
      count_d      = '0;
      qual_d       = 1'b0;
      seen_d       = 1'b0;
      held_valid_d = 1'b0;
      held_d       = '0;
      dropped_d    = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q      <= '0;
      head_q       <= '0;
      left_q       <= '0;
      qual_q       <= 1'b0;
      seen_q       <= 1'b0;
      held_valid_q <= 1'b0;
      held_q       <= '0;
      dropped_q    <= 1'b0;
      start_q      <= '0;
      pos_q        <= '0;
      min_len_q    <= prx_pkg::MinLengthReset;
      out_valid_q  <= 1'b0;
    end else begin
      count_q      <= count_d;
      head_q       <= head_d;
      left_q       <= left_d;
      qual_q       <= qual_d;
      seen_q       <= seen_d;
      held_valid_q <= held_valid_d;
      held_q       <= held_d;
      dropped_q    <= dropped_d;
      start_q      <= start_d;
      pos_q        <= pos_d;
      min_len_q    <= min_len_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q <= in_req_i.data_byte;
      end_q  <= in_req_i.stream_end;
    end
    if (cmd_i.push) begin
      pend_mem[tail] <= byte_q;
    end
    if (cmd_i.drain_rd) begin
      rdata_q <= pend_mem[head_q];
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

/* sv/prx_checker.sv */
// Port-level checks for printable_run_extractor_unit, attached by bind.
// Depends on prx_pkg and printable_run_extractor_unit_macros.svh.
`include "printable_run_extractor_unit_macros.svh"

module prx_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_o,
  input prx_pkg::in_req_t  in_req_i,
  input logic              out_valid_o,
  input logic              out_stall_i,
  input prx_pkg::out_req_t out_req_o
);

  logic char_ok;

  assign char_ok = ((out_req_o.char_out >= prx_pkg::CharSpace)
                    && (out_req_o.char_out <= prx_pkg::CharTilde))
                   || (out_req_o.char_out == prx_pkg::CharTab);

  `PRX_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_req_o))
  `PRX_ASSERT_NEXT(a_in_hold, in_valid_i && in_stall_o, in_valid_i && $stable(in_req_i))
  `PRX_ASSERT_NEXT(a_in_busy, in_valid_i && !in_stall_o, in_stall_o)
  `PRX_ASSERT_IMPL(a_char_printable, out_valid_o, char_ok)

endmodule

bind printable_run_extractor_unit prx_checker u_prx_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_req_i    (in_req_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_req_o   (out_req_o)
);

/* tb/printable_run_extractor_unit_test.sv */
// Self-checking testbench for printable_run_extractor_unit: a scoreboard class
// predicts the reported run bytes, and plain tasks drive requests and the register.
// Depends on prx_pkg and the printable_run_extractor_unit RTL only.
`timescale 1ns / 1ps

function automatic bit is_printable(logic [7:0] b);
  return (b >= prx_pkg::CharSpace && b <= prx_pkg::CharTilde) || b == prx_pkg::CharTab;
endfunction

class run_scoreboard;
  logic [7:0]        pending_run[$];
  bit                qualified;
  bit                seen_visible;
  bit                held_valid;
  bit                dropped;
  logic [7:0]        held_byte;
  logic [31:0]       run_start;
  logic [31:0]       stream_pos;
  logic [5:0]        min_length;
  prx_pkg::out_req_t expected_bytes[$];
  int unsigned       mismatches;
  int unsigned       requests;
  int unsigned       results;
  int unsigned       truncated_results;
  int unsigned       runs;

  function new();
    min_length = prx_pkg::MinLengthReset;
    run_start = '0;
    stream_pos = '0;
    clear_run();
    mismatches = 0;
    requests = 0;
    results = 0;
    truncated_results = 0;
    runs = 0;
  endfunction

  function void clear_run();
    pending_run.delete();
    qualified = 1'b0;
    seen_visible = 1'b0;
    held_valid = 1'b0;
    held_byte = '0;
    dropped = 1'b0;
  endfunction

  function void expect_byte(logic [7:0] c, bit last);
    prx_pkg::out_req_t r;
    r.char_out = c;
    r.run_offset = run_start;
    r.last_of_run = last;
    r.truncated = dropped;
    expected_bytes.push_back(r);
  endfunction

  function void note_request(prx_pkg::in_req_t req);
    int unsigned thr;
    logic [7:0]  b;
    bit          printable;
    b = req.data_byte;
    printable = is_printable(b);
    thr = (min_length == 0) ? 1 : min_length;
    if (thr > prx_pkg::PendingDepth) thr = prx_pkg::PendingDepth;
    requests++;
    if (pending_run.size() == 0 && !qualified) run_start = stream_pos;
    if (printable) begin
      if (qualified) begin
        if (held_valid) expect_byte(held_byte, 1'b0);
        held_byte = b;
        held_valid = 1'b1;
      end else begin
        if (pending_run.size() >= prx_pkg::PendingDepth) begin
          void'(pending_run.pop_front());
          dropped = 1'b1;
        end
        pending_run.push_back(b);
        if (b >= prx_pkg::CharVisLow && b <= prx_pkg::CharTilde) seen_visible = 1'b1;
        if (pending_run.size() >= thr && seen_visible) begin
          qualified = 1'b1;
          held_byte = pending_run.pop_back();
          held_valid = 1'b1;
          while (pending_run.size() != 0) expect_byte(pending_run.pop_front(), 1'b0);
        end
      end
    end
    if (!printable || req.stream_end) begin
      if (qualified && held_valid) expect_byte(held_byte, 1'b1);
      clear_run();
    end
    stream_pos = req.stream_end ? 32'd0 : stream_pos + 32'd1;
  endfunction

  task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40) begin
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    end
  endtask

  task check_result(prx_pkg::out_req_t got);
    prx_pkg::out_req_t want;
    results++;
    if (got.truncated) truncated_results++;
    if (got.last_of_run) runs++;
    if (expected_bytes.size() == 0) begin
      report_mismatch("unexpected result char_out", 32'(got.char_out), 32'd0);
      return;
    end
    want = expected_bytes.pop_front();
    if (got.char_out !== want.char_out) begin
      report_mismatch("char_out", 32'(got.char_out), 32'(want.char_out));
    end
    if (got.run_offset !== want.run_offset) begin
      report_mismatch("run_offset", got.run_offset, want.run_offset);
    end
    if (got.last_of_run !== want.last_of_run) begin
      report_mismatch("last_of_run", 32'(got.last_of_run), 32'(want.last_of_run));
    end
    if (got.truncated !== want.truncated) begin
      report_mismatch("truncated", 32'(got.truncated), 32'(want.truncated));
    end
  endtask
endclass

module printable_run_extractor_unit_test;

  localparam int unsigned CycleLimit = 2000000;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [5:0]        cfg_wdata_i;
  logic              in_valid_i;
  logic              in_stall_o;
  prx_pkg::in_req_t  in_req_i;
  logic              out_valid_o;
  logic              out_stall_i;
  prx_pkg::out_req_t out_req_o;

  run_scoreboard sb = new();
  bit            idle_en;
  bit            long_hold_req;
  int unsigned   items_sent;
  int unsigned   cycle_count;
  string         settings_used;

  printable_run_extractor_unit uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.min_length = cfg_wdata_i;
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_req_o);
    end
  end

  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
             sb.expected_bytes.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : result_side
    int unsigned burst;
    int unsigned hold_left;
    out_stall_i = 1'b0;
    burst = 0;
    hold_left = 0;
    forever begin
      @(negedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold_left = 200;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall_i <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        burst = $urandom_range(1, 8) - 1;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  function automatic prx_pkg::in_req_t make_req(logic [7:0] b, logic e);
    prx_pkg::in_req_t r;
    r.data_byte = b;
    r.stream_end = e;
    return r;
  endfunction

  function automatic logic [7:0] blank_char();
    return ($urandom_range(0, 1) == 0) ? prx_pkg::CharTab : prx_pkg::CharSpace;
  endfunction

  function automatic logic [7:0] printable_char();
    if ($urandom_range(0, 3) == 0) return blank_char();
    return 8'($urandom_range(prx_pkg::CharVisLow, prx_pkg::CharTilde));
  endfunction

  function automatic logic [7:0] breaker_char();
    logic [7:0] b;
    b = 8'($urandom);
    while (is_printable(b)) b = 8'($urandom);
    return b;
  endfunction

  task automatic send_byte(input prx_pkg::in_req_t req);
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i <= req;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic wait_drained(input int unsigned settle);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_min_length(input logic [5:0] value);
    wait_drained(8);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    settings_used = {settings_used, $sformatf(" %0d", value)};
  endtask

  // Blank prefix, then len printable bytes, then a break or a final byte.
  task automatic send_run(input int unsigned blanks, input int unsigned len);
    int unsigned k;
    bit          end_on_last;
    end_on_last = (len != 0) && ($urandom_range(0, 5) == 0);
    for (k = 0; k < blanks; k++) send_byte(make_req(blank_char(), 1'b0));
    for (k = 0; k < len; k++) begin
      send_byte(make_req(printable_char(), end_on_last && k == len - 1));
    end
    if (!end_on_last) send_byte(make_req(breaker_char(), $urandom_range(0, 7) == 0));
  endtask

  task automatic random_phase(input int unsigned n_items, input int unsigned pause_at);
    int unsigned first;
    int unsigned thr;
    bit          paused;
    first = items_sent;
    paused = 1'b0;
    while (items_sent - first < n_items) begin
      if (!paused && pause_at != 0 && items_sent - first >= pause_at) begin
        wait_drained(0);
        paused = 1'b1;
      end
      thr = (sb.min_length == 0) ? 1 : sb.min_length;
      case ($urandom_range(0, 9))
        0: send_byte(make_req(8'($urandom), $urandom_range(0, 7) == 0));
        1: send_run($urandom_range(1, thr + 2), 0);
        default: send_run($urandom_range(0, 2), $urandom_range(thr > 3 ? thr - 3 : 1, thr + 5));
      endcase
    end
  endtask

  initial begin : stimulus
    int unsigned k;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_req_i = '0;
    idle_en = 1'b1;
    long_hold_req = 1'b0;
    items_sent = 0;
    settings_used = " 4";
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Short run ends unreported.
    send_byte(make_req(8'h41, 1'b0));
    send_byte(make_req(8'h62, 1'b0));
    send_byte(make_req(8'h00, 1'b0));
    // Qualify at the fourth byte, end on the top byte value.
    send_byte(make_req(prx_pkg::CharTilde, 1'b0));
    send_byte(make_req(prx_pkg::CharVisLow, 1'b0));
    send_byte(make_req(prx_pkg::CharSpace, 1'b0));
    send_byte(make_req(prx_pkg::CharTab, 1'b0));
    send_byte(make_req(8'hFF, 1'b0));
    // Blank-only run.
    send_byte(make_req(prx_pkg::CharSpace, 1'b0));
    send_byte(make_req(prx_pkg::CharTab, 1'b0));
    send_byte(make_req(prx_pkg::CharSpace, 1'b0));
    send_byte(make_req(prx_pkg::CharTab, 1'b0));
    send_byte(make_req(8'h7F, 1'b0));
    // Final printable byte joins the run.
    send_byte(make_req(8'h77, 1'b0));
    send_byte(make_req(8'h78, 1'b0));
    send_byte(make_req(8'h79, 1'b0));
    send_byte(make_req(8'h7A, 1'b1));
    send_byte(make_req(8'h80, 1'b1));
    // Pass-through after qualifying.
    send_byte(make_req(8'h48, 1'b0));
    send_byte(make_req(8'h65, 1'b0));
    send_byte(make_req(8'h6C, 1'b0));
    send_byte(make_req(8'h6C, 1'b0));
    send_byte(make_req(8'h6F, 1'b0));
    send_byte(make_req(8'h2C, 1'b0));
    send_byte(make_req(prx_pkg::CharSpace, 1'b0));
    send_byte(make_req(8'h1F, 1'b0));

    write_min_length(6'd1);
    long_hold_req = 1'b1;
    random_phase(40, 0);

    // Overflow the pending buffer with blanks, then qualify at full depth.
    write_min_length(6'd63);
    for (k = 0; k < 66; k++) send_byte(make_req(blank_char(), 1'b0));
    send_byte(make_req(8'($urandom_range(prx_pkg::CharVisLow, prx_pkg::CharTilde)), 1'b0));
    for (k = 0; k < 3; k++) send_byte(make_req(printable_char(), 1'b0));
    send_byte(make_req(breaker_char(), 1'b0));

    write_min_length(6'd0);
    random_phase(30, 0);

    write_min_length(6'($urandom_range(2, 12)));
    random_phase(50, 25);

    idle_en = 1'b0;
    write_min_length(prx_pkg::MinLengthReset);
    random_phase(40, 0);

    wait_drained(16);
    if (sb.expected_bytes.size() != 0) begin
      sb.report_mismatch("results never seen", 32'(sb.expected_bytes.size()), 32'd0);
    end
    $display("covered %0d requests, %0d result bytes in %0d reported runs (%0d truncated)",
             sb.requests, sb.results, sb.runs, sb.truncated_results);
    $display("min_length settings:%s, %0d cycles", settings_used, cycle_count);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/prx_pkg.sv
sv/prx_ctrl.sv
sv/prx_datapath.sv
sv/printable_run_extractor_unit.sv
sv/prx_checker.sv
tb/printable_run_extractor_unit_test.sv
